[rtl/general_purpose_timer_regs_unit_macros.svh]
// Assertion helpers shared by the timer register block
`ifndef GENERAL_PURPOSE_TIMER_REGS_UNIT_MACROS_SVH
`define GENERAL_PURPOSE_TIMER_REGS_UNIT_MACROS_SVH

// expr holds at every clock edge out of reset
`define GPTR_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: invariant violated");

// ante at one edge implies cons at the next edge
`define GPTR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: sequence violated");

`endif

[rtl/gptr_pkg.sv]
package gptr_pkg;

    localparam int COUNTER_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam logic [4:0] REG_ID        = 5'd0;
    localparam logic [4:0] REG_SYSCONFIG = 5'd4;
    localparam logic [4:0] REG_SYSSTATUS = 5'd5;
    localparam logic [4:0] REG_STATUS    = 5'd6;
    localparam logic [4:0] REG_IRQEN     = 5'd7;
    localparam logic [4:0] REG_WAKEUP    = 5'd8;
    localparam logic [4:0] REG_CONTROL   = 5'd9;
    localparam logic [4:0] REG_COUNTER   = 5'd10;
    localparam logic [4:0] REG_LOAD      = 5'd11;
    localparam logic [4:0] REG_TRIGGER   = 5'd12;
    localparam logic [4:0] REG_POSTED    = 5'd13;
    localparam logic [4:0] REG_MATCH     = 5'd14;
    localparam logic [4:0] REG_CAPTURE1  = 5'd15;
    localparam logic [4:0] REG_IFCTRL    = 5'd16;
    localparam logic [4:0] REG_CAPTURE2  = 5'd17;
    localparam logic [4:0] REG_FILT0     = 5'd18;
    localparam logic [4:0] REG_FILT1     = 5'd19;
    localparam logic [4:0] REG_FILT2     = 5'd20;
    localparam logic [4:0] REG_FILT3     = 5'd21;
    localparam logic [4:0] REG_FILT4     = 5'd22;

    localparam int CTL_ST  = 0;
    localparam int CTL_AR  = 1;
    localparam int CTL_PTV = 2;
    localparam int CTL_PRE = 5;
    localparam int CTL_CE  = 6;
    localparam int CTL_W   = 15;
    localparam logic [31:0] CTL_PINS = 32'h0000_7F80;

    localparam int SFT_BIT    = 1;
    localparam int POSTED_BIT = 2;
    localparam int FLAG_W     = 3;
    localparam int FLAG_MAT   = 0;
    localparam int FLAG_OVF   = 1;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_RD_ONE,
        OP_RD_STATUS,
        OP_RD_IRQEN,
        OP_RD_CTRL,
        OP_RD_COUNT,
        OP_RD_LOAD,
        OP_RD_ONES,
        OP_RD_MATCH,
        OP_RD_POSTED,
        OP_SOFT_RESET,
        OP_WR_STATUS,
        OP_WR_IRQEN,
        OP_WR_CTRL,
        OP_WR_COUNT,
        OP_WR_LOAD,
        OP_TRIGGER,
        OP_WR_MATCH,
        OP_WR_IFCTRL,
        OP_TICK
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] data;
        logic        bad;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq;
        logic        bad_access;
    } res_t;

endpackage

[rtl/general_purpose_timer_regs_unit.sv]
// A request accepted into the command queue is executed by the back end and its result is
// registered into the result queue, from which it shows on the result ports; a full result
// queue stalls the back end, which otherwise takes one request per cycle when one is queued.
// Two-entry queues between front, back and result ports absorb stalls on either side.
// Reset (rst_n low, asynchronous): timer state cleared, posted bit set, queues emptied.
module general_purpose_timer_regs_unit #(
    parameter int COUNTER_WIDTH = gptr_pkg::COUNTER_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  action,
    input  logic [4:0]  reg_index,
    input  logic [31:0] write_data,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] read_data,
    output logic        irq,
    output logic        bad_access
);
    localparam int REQ_W = $bits(gptr_pkg::req_t);
    localparam int RES_W = $bits(gptr_pkg::res_t);

    gptr_pkg::req_t front_req;
    gptr_pkg::req_t cmd;
    logic           cmd_empty;
    logic           cmd_pop;
    gptr_pkg::res_t back_res;
    gptr_pkg::res_t out_res;
    logic           res_full;
    logic           res_push;

    gptr_front u_front (
        .action     (action),
        .reg_index  (reg_index),
        .write_data (write_data),
        .req        (front_req)
    );

    gptr_fifo #(
        .WIDTH (REQ_W),
        .DEPTH (gptr_pkg::QUEUE_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (front_req),
        .full    (full),
        .pop     (cmd_pop),
        .rd_data (cmd),
        .empty   (cmd_empty)
    );

    gptr_back #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (back_res)
    );

    gptr_fifo #(
        .WIDTH (RES_W),
        .DEPTH (gptr_pkg::QUEUE_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (back_res),
        .full    (res_full),
        .pop     (pop),
        .rd_data (out_res),
        .empty   (empty)
    );

    assign read_data  = out_res.read_data;
    assign irq        = out_res.irq;
    assign bad_access = out_res.bad_access;

endmodule

[rtl/gptr_fifo.sv]
`include "general_purpose_timer_regs_unit_macros.svh"

module gptr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `GPTR_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH))
    `GPTR_ASSERT_NEXT(a_push_data, clk, rst_n, do_push && empty, rd_data == $past(wr_data))

endmodule

[rtl/gptr_front.sv]
module gptr_front (
    input  logic               [1:0]  action,
    input  logic               [4:0]  reg_index,
    input  logic               [31:0] write_data,
    output gptr_pkg::req_t            req
);
    always_comb
    begin
        req.op   = gptr_pkg::OP_NOP;
        req.data = write_data;
        req.bad  = 1'b0;
        unique case (action)
            gptr_pkg::ACT_READ:
            begin
                unique case (reg_index)
                    gptr_pkg::REG_ID, gptr_pkg::REG_POSTED, gptr_pkg::REG_CAPTURE1,
                    gptr_pkg::REG_CAPTURE2, gptr_pkg::REG_FILT0, gptr_pkg::REG_FILT1,
                    gptr_pkg::REG_FILT2, gptr_pkg::REG_FILT3, gptr_pkg::REG_FILT4:
                        req.op = gptr_pkg::OP_NOP;
                    gptr_pkg::REG_SYSSTATUS: req.op = gptr_pkg::OP_RD_ONE;
                    gptr_pkg::REG_STATUS:    req.op = gptr_pkg::OP_RD_STATUS;
                    gptr_pkg::REG_IRQEN:     req.op = gptr_pkg::OP_RD_IRQEN;
                    gptr_pkg::REG_CONTROL:   req.op = gptr_pkg::OP_RD_CTRL;
                    gptr_pkg::REG_COUNTER:   req.op = gptr_pkg::OP_RD_COUNT;
                    gptr_pkg::REG_LOAD:      req.op = gptr_pkg::OP_RD_LOAD;
                    gptr_pkg::REG_TRIGGER:   req.op = gptr_pkg::OP_RD_ONES;
                    gptr_pkg::REG_MATCH:     req.op = gptr_pkg::OP_RD_MATCH;
                    gptr_pkg::REG_IFCTRL:    req.op = gptr_pkg::OP_RD_POSTED;
                    default:                 req.bad = 1'b1;
                endcase
            end
            gptr_pkg::ACT_WRITE:
            begin
                unique case (reg_index)
                    gptr_pkg::REG_ID, gptr_pkg::REG_SYSSTATUS, gptr_pkg::REG_WAKEUP,
                    gptr_pkg::REG_POSTED, gptr_pkg::REG_CAPTURE1, gptr_pkg::REG_CAPTURE2:
                        req.op = gptr_pkg::OP_NOP;
                    gptr_pkg::REG_SYSCONFIG:
                        req.op = write_data[gptr_pkg::SFT_BIT] ? gptr_pkg::OP_SOFT_RESET
                                                               : gptr_pkg::OP_NOP;
                    gptr_pkg::REG_STATUS:  req.op = gptr_pkg::OP_WR_STATUS;
                    gptr_pkg::REG_IRQEN:   req.op = gptr_pkg::OP_WR_IRQEN;
                    gptr_pkg::REG_CONTROL:
                    begin
                        if ((write_data & gptr_pkg::CTL_PINS) != '0)
                        begin
                            req.bad = 1'b1;
                        end
                        else
                        begin
                            req.op = gptr_pkg::OP_WR_CTRL;
                        end
                    end
                    gptr_pkg::REG_COUNTER: req.op = gptr_pkg::OP_WR_COUNT;
                    gptr_pkg::REG_LOAD:    req.op = gptr_pkg::OP_WR_LOAD;
                    gptr_pkg::REG_TRIGGER: req.op = gptr_pkg::OP_TRIGGER;
                    gptr_pkg::REG_MATCH:   req.op = gptr_pkg::OP_WR_MATCH;
                    gptr_pkg::REG_IFCTRL:  req.op = gptr_pkg::OP_WR_IFCTRL;
                    gptr_pkg::REG_FILT0, gptr_pkg::REG_FILT1, gptr_pkg::REG_FILT2,
                    gptr_pkg::REG_FILT3, gptr_pkg::REG_FILT4:
                        req.bad = (write_data != '0);
                    default:               req.bad = 1'b1;
                endcase
            end
            gptr_pkg::ACT_TICK: req.op = gptr_pkg::OP_TICK;
            gptr_pkg::ACT_NONE: req.op = gptr_pkg::OP_NOP;
        endcase
    end

endmodule

[rtl/gptr_back.sv]
`include "general_purpose_timer_regs_unit_macros.svh"

module gptr_back #(
    parameter int COUNTER_WIDTH = gptr_pkg::COUNTER_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_empty,
    input  gptr_pkg::req_t cmd,
    output logic           cmd_pop,
    input  logic           res_full,
    output logic           res_push,
    output gptr_pkg::res_t res
);
    localparam int FW = gptr_pkg::FLAG_W;
    localparam int CW = gptr_pkg::CTL_W;

    logic [FW-1:0]            flags_reg, flags_next;
    logic [FW-1:0]            irqen_reg, irqen_next;
    logic [CW-1:0]            ctrl_reg, ctrl_next;
    logic [31:0]              load_reg, load_next;
    logic [31:0]              match_reg, match_next;
    logic                     posted_reg, posted_next;
    logic [COUNTER_WIDTH-1:0] count_reg, count_next;
    logic [7:0]               phase_reg, phase_next;
    logic                     running_reg, running_next;
    logic                     osd_reg, osd_next;

    logic                     fire;
    logic [CW-1:0]            nc;
    logic [8:0]               period;
    logic [8:0]               phase_inc;
    logic [COUNTER_WIDTH-1:0] count_inc;
    logic                     same_period;

    assign fire     = !cmd_empty && !res_full;
    assign cmd_pop  = fire;
    assign res_push = fire;

    assign nc        = cmd.data[CW-1:0];
    assign period    = ctrl_reg[gptr_pkg::CTL_PRE]
                     ? (9'd1 << ({1'b0, ctrl_reg[gptr_pkg::CTL_PTV +: 3]} + 4'd1)) : 9'd1;
    assign phase_inc = {1'b0, phase_reg} + 9'd1;
    assign count_inc = count_reg + 1'b1;
    assign same_period = (nc[gptr_pkg::CTL_PRE] == ctrl_reg[gptr_pkg::CTL_PRE])
                      && (!nc[gptr_pkg::CTL_PRE]
                          || nc[gptr_pkg::CTL_PTV +: 3] == ctrl_reg[gptr_pkg::CTL_PTV +: 3]);

    always_comb
    begin
        flags_next   = flags_reg;
        irqen_next   = irqen_reg;
        ctrl_next    = ctrl_reg;
        load_next    = load_reg;
        match_next   = match_reg;
        posted_next  = posted_reg;
        count_next   = count_reg;
        phase_next   = phase_reg;
        running_next = running_reg;
        osd_next     = osd_reg;
        res.read_data = '0;
        res.bad_access = cmd.bad;
        if (fire)
        begin
            unique case (cmd.op)
                gptr_pkg::OP_NOP:       res.read_data = '0;
                gptr_pkg::OP_RD_ONE:    res.read_data = 32'd1;
                gptr_pkg::OP_RD_STATUS: res.read_data = 32'(flags_reg);
                gptr_pkg::OP_RD_IRQEN:  res.read_data = 32'(irqen_reg);
                gptr_pkg::OP_RD_CTRL:   res.read_data = 32'(ctrl_reg);
                gptr_pkg::OP_RD_COUNT:  res.read_data = 32'(count_reg);
                gptr_pkg::OP_RD_LOAD:   res.read_data = load_reg;
                gptr_pkg::OP_RD_ONES:   res.read_data = '1;
                gptr_pkg::OP_RD_MATCH:  res.read_data = match_reg;
                gptr_pkg::OP_RD_POSTED: res.read_data = 32'(posted_reg) << gptr_pkg::POSTED_BIT;
                gptr_pkg::OP_SOFT_RESET, gptr_pkg::OP_WR_IFCTRL:
                begin
                    if (cmd.op == gptr_pkg::OP_SOFT_RESET || cmd.data[gptr_pkg::SFT_BIT])
                    begin
                        flags_next   = '0;
                        irqen_next   = '0;
                        ctrl_next    = '0;
                        load_next    = '0;
                        match_next   = '0;
                        count_next   = '0;
                        phase_next   = '0;
                        running_next = 1'b0;
                        osd_next     = 1'b0;
                    end
                    posted_next = (cmd.op == gptr_pkg::OP_SOFT_RESET)
                                || cmd.data[gptr_pkg::POSTED_BIT];
                end
                gptr_pkg::OP_WR_STATUS: flags_next = flags_reg & ~cmd.data[FW-1:0];
                gptr_pkg::OP_WR_IRQEN:  irqen_next = cmd.data[FW-1:0];
                gptr_pkg::OP_WR_CTRL:
                begin
                    ctrl_next = nc;
                    if (!same_period)
                    begin
                        phase_next = '0;
                    end
                    if (!nc[gptr_pkg::CTL_ST])
                    begin
                        running_next = 1'b0;
                        osd_next     = 1'b0;
                    end
                    else if (!running_reg && !osd_reg)
                    begin
                        running_next = 1'b1;
                        phase_next   = '0;
                    end
                end
                gptr_pkg::OP_WR_COUNT, gptr_pkg::OP_TRIGGER:
                begin
                    count_next   = (cmd.op == gptr_pkg::OP_TRIGGER)
                                 ? load_reg[COUNTER_WIDTH-1:0] : cmd.data[COUNTER_WIDTH-1:0];
                    phase_next   = '0;
                    osd_next     = 1'b0;
                    running_next = ctrl_reg[gptr_pkg::CTL_ST];
                end
                gptr_pkg::OP_WR_LOAD:   load_next  = cmd.data;
                gptr_pkg::OP_WR_MATCH:  match_next = cmd.data;
                gptr_pkg::OP_TICK:
                begin
                    if (running_reg)
                    begin
                        if (phase_inc < period)
                        begin
                            phase_next = phase_inc[7:0];
                        end
                        else
                        begin
                            phase_next = '0;
                            if (count_reg == '1)
                            begin
                                flags_next[gptr_pkg::FLAG_OVF] = 1'b1;
                                if (ctrl_reg[gptr_pkg::CTL_AR])
                                begin
                                    count_next = load_reg[COUNTER_WIDTH-1:0];
                                    osd_next   = 1'b0;
                                end
                                else
                                begin
                                    count_next   = '0;
                                    running_next = 1'b0;
                                    osd_next     = 1'b1;
                                end
                            end
                            else
                            begin
                                count_next = count_inc;
                                if (ctrl_reg[gptr_pkg::CTL_CE] && 32'(count_inc) == match_reg)
                                begin
                                    flags_next[gptr_pkg::FLAG_MAT] = 1'b1;
                                end
                            end
                        end
                    end
                end
                default: res.read_data = '0;
            endcase
        end
        res.irq = (flags_next & irqen_next) != '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg   <= '0;
            irqen_reg   <= '0;
            ctrl_reg    <= '0;
            load_reg    <= '0;
            match_reg   <= '0;
            posted_reg  <= 1'b1;
            count_reg   <= '0;
            phase_reg   <= '0;
            running_reg <= 1'b0;
            osd_reg     <= 1'b0;
        end
        else
        begin
            flags_reg   <= flags_next;
            irqen_reg   <= irqen_next;
            ctrl_reg    <= ctrl_next;
            load_reg    <= load_next;
            match_reg   <= match_next;
            posted_reg  <= posted_next;
            count_reg   <= count_next;
            phase_reg   <= phase_next;
            running_reg <= running_next;
            osd_reg     <= osd_next;
        end
    end

    `GPTR_ASSERT_ALWAYS(a_done_stopped, clk, rst_n, !(osd_reg && running_reg))
    `GPTR_ASSERT_NEXT(a_idle_tick, clk, rst_n,
        fire && cmd.op == gptr_pkg::OP_TICK && !running_reg,
        $stable(count_reg) && $stable(phase_reg))

endmodule
